FILE: src/alte_pkg.sv
// Shared types and constants for the array list table engine.
package alte_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [CFG_DATA_W-1:0] CAP_RESET = 6'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_GET    = 3'd3,
    CMD_SET    = 3'd4,
    CMD_SEARCH = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_MISS  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    POL_PLAIN     = 2'd0,
    POL_TRANSPOSE = 2'd1,
    POL_FRONT     = 2'd2
  } policy_e;

  // Datapath micro-operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_APPEND,
    DP_SET,
    DP_RD_POS,
    DP_GRAB,
    DP_DEL_STEP,
    DP_DEL_END,
    DP_INS_INIT,
    DP_INS_STEP,
    DP_INS_PUT,
    DP_SRCH_INIT,
    DP_SRCH_STEP,
    DP_HIT,
    DP_SWAP_TAIL,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    st_we;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             can_add;
    logic             pos_le_cnt;
    logic             pos_lt_cnt;
    logic             ins_done;
    logic             scan_done;
    logic             hit;
    logic             swap_need;
  } dp_stat_t;

endpackage

FILE: src/alte_if.sv
// Handshake interfaces for the command, result and configuration channels.
interface alte_req_if;
  logic                               valid;
  logic                               ready;
  logic [alte_pkg::CMD_W-1:0]         command;
  logic [alte_pkg::POS_W-1:0]         position;
  logic signed [alte_pkg::DATA_W-1:0] operand_value;

  modport source (output valid, command, position, operand_value, input ready);
  modport sink   (input valid, command, position, operand_value, output ready);
endinterface

interface alte_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [alte_pkg::STAT_W-1:0]        status;
  logic signed [alte_pkg::DATA_W-1:0] read_value;
  logic [alte_pkg::POS_W-1:0]         found_position;
  logic [alte_pkg::CNT_W-1:0]         entry_total;

  modport source (output valid, status, read_value, found_position, entry_total,
                  input ready);
  modport sink   (input valid, status, read_value, found_position, entry_total,
                  output ready);
endinterface

interface alte_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [alte_pkg::CFG_IDX_W-1:0]    index;
  logic [alte_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/alte_datapath.sv
// List storage, walk pointers, compare and result registers.
module alte_datapath #(
  parameter int unsigned LIST_CAPACITY = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  alte_pkg::dp_cmd_t                   cmd_i,
  output alte_pkg::dp_stat_t                  stat_o,
  input  logic [alte_pkg::CMD_W-1:0]          command_i,
  input  logic [alte_pkg::POS_W-1:0]          position_i,
  input  logic signed [alte_pkg::DATA_W-1:0]  operand_value_i,
  input  logic                                cfg_we_i,
  input  logic [alte_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [alte_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic [alte_pkg::STAT_W-1:0]         status_o,
  output logic signed [alte_pkg::DATA_W-1:0]  read_value_o,
  output logic [alte_pkg::POS_W-1:0]          found_position_o,
  output logic [alte_pkg::CNT_W-1:0]          entry_total_o
);

  localparam int unsigned AW      = $clog2(LIST_CAPACITY);
  localparam int unsigned CntW    = alte_pkg::CNT_W;
  localparam int unsigned PosW    = alte_pkg::POS_W;
  localparam int unsigned DataW   = alte_pkg::DATA_W;
  localparam int unsigned CntMax  = (1 << CntW) - 1;
  localparam int unsigned CapClip = (LIST_CAPACITY > CntMax) ? CntMax : LIST_CAPACITY;
  localparam logic [CntW-1:0] CAP_CLIP = CntW'(CapClip);

  logic signed [DataW-1:0] mem [LIST_CAPACITY];

  logic [alte_pkg::CMD_W-1:0] cmd_q;
  logic [PosW-1:0]            pos_q;
  logic signed [DataW-1:0]    val_q;
  logic [CntW-1:0]            cnt_q;
  logic [CntW-1:0]            rp_q;
  logic [CntW-1:0]            wp_q;
  logic                       pend_q;
  logic signed [DataW-1:0]    rdata_q;
  logic signed [DataW-1:0]    prev_q;
  logic signed [DataW-1:0]    head_q;
  logic [1:0]                 policy_q;
  logic [CntW-1:0]            cap_q;

  alte_pkg::status_e          st_res_q;
  logic signed [DataW-1:0]    rd_res_q;
  logic [PosW-1:0]            found_res_q;

  alte_pkg::status_e          out_status_q;
  logic signed [DataW-1:0]    out_rd_q;
  logic [PosW-1:0]            out_found_q;
  logic [CntW-1:0]            out_total_q;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic signed [DataW-1:0]    mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;

  logic [CntW-1:0]            pos_ext;
  logic                       rp_below_cnt;
  logic                       rp_above_pos;
  logic                       transpose;

  assign pos_ext      = CntW'(pos_q);
  assign rp_below_cnt = rp_q < cnt_q;
  assign rp_above_pos = rp_q > pos_ext;
  assign transpose    = policy_q == alte_pkg::POL_TRANSPOSE;

  always_comb begin
    stat_o.cmd        = cmd_q;
    stat_o.can_add    = (cnt_q < cap_q) && (cnt_q < CAP_CLIP);
    stat_o.pos_le_cnt = pos_ext <= cnt_q;
    stat_o.pos_lt_cnt = pos_ext < cnt_q;
    stat_o.ins_done   = (rp_q == pos_ext) && !pend_q;
    stat_o.scan_done  = !rp_below_cnt && !pend_q;
    stat_o.hit        = pend_q && (rdata_q == val_q);
    stat_o.swap_need  = (transpose || policy_q == alte_pkg::POL_FRONT) && (wp_q != '0);
  end

  // Memory port selection per micro-operation.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(wp_q);
    mem_wdata = rdata_q;
    mem_re    = 1'b0;
    mem_raddr = AW'(rp_q);
    case (cmd_i.op)
      alte_pkg::DP_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = val_q;
      end
      alte_pkg::DP_SET, alte_pkg::DP_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_q);
        mem_wdata = val_q;
      end
      alte_pkg::DP_RD_POS: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(pos_q);
      end
      alte_pkg::DP_DEL_STEP: begin
        mem_we = pend_q;
        mem_re = rp_below_cnt;
      end
      alte_pkg::DP_INS_STEP: begin
        mem_we    = pend_q;
        mem_re    = rp_above_pos;
        mem_raddr = AW'(rp_q - CntW'(1));
      end
      alte_pkg::DP_SRCH_STEP: begin
        mem_re = rp_below_cnt;
      end
      alte_pkg::DP_HIT: begin
        mem_we    = stat_o.swap_need;
        mem_wdata = transpose ? prev_q : head_q;
      end
      alte_pkg::DP_SWAP_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = transpose ? AW'(wp_q - CntW'(1)) : '0;
        mem_wdata = val_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Control registers: count, walk flag and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      pend_q   <= 1'b0;
      policy_q <= alte_pkg::POL_PLAIN;
      cap_q    <= alte_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          alte_pkg::CFG_SEARCH_POLICY:  policy_q <= cfg_data_i[1:0];
          alte_pkg::CFG_CAPACITY_LIMIT: cap_q    <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        alte_pkg::DP_APPEND, alte_pkg::DP_INS_PUT: cnt_q <= cnt_q + CntW'(1);
        alte_pkg::DP_DEL_END:                      cnt_q <= cnt_q - CntW'(1);
        alte_pkg::DP_RD_POS, alte_pkg::DP_INS_INIT,
        alte_pkg::DP_SRCH_INIT:                    pend_q <= 1'b0;
        alte_pkg::DP_DEL_STEP, alte_pkg::DP_SRCH_STEP: pend_q <= rp_below_cnt;
        alte_pkg::DP_INS_STEP:                     pend_q <= rp_above_pos;
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      alte_pkg::DP_LOAD: begin
        cmd_q       <= command_i;
        pos_q       <= position_i;
        val_q       <= operand_value_i;
        rd_res_q    <= '0;
        found_res_q <= '0;
        st_res_q    <= alte_pkg::ST_RANGE;
      end
      alte_pkg::DP_RD_POS: begin
        rp_q <= pos_ext + CntW'(1);
        wp_q <= pos_ext;
      end
      alte_pkg::DP_GRAB: begin
        rd_res_q <= rdata_q;
      end
      alte_pkg::DP_DEL_STEP: begin
        if (pend_q) wp_q <= wp_q + CntW'(1);
        if (rp_below_cnt) rp_q <= rp_q + CntW'(1);
      end
      alte_pkg::DP_INS_INIT: begin
        rp_q <= cnt_q;
        wp_q <= cnt_q;
      end
      alte_pkg::DP_INS_STEP: begin
        if (pend_q) wp_q <= wp_q - CntW'(1);
        if (rp_above_pos) rp_q <= rp_q - CntW'(1);
      end
      alte_pkg::DP_SRCH_INIT: begin
        rp_q <= '0;
        wp_q <= '0;
      end
      alte_pkg::DP_SRCH_STEP: begin
        if (pend_q) begin
          prev_q <= rdata_q;
          if (wp_q == '0) head_q <= rdata_q;
          wp_q <= wp_q + CntW'(1);
        end
        if (rp_below_cnt) rp_q <= rp_q + CntW'(1);
      end
      alte_pkg::DP_HIT: begin
        found_res_q <= wp_q[PosW-1:0];
      end
      alte_pkg::DP_EMIT: begin
        out_status_q <= st_res_q;
        out_rd_q     <= rd_res_q;
        out_found_q  <= found_res_q;
        out_total_q  <= cnt_q;
      end
      default: begin
      end
    endcase
    if (cmd_i.st_we) begin
      st_res_q <= cmd_i.st;
    end
  end

  assign status_o         = out_status_q;
  assign read_value_o     = out_rd_q;
  assign found_position_o = out_found_q;
  assign entry_total_o    = out_total_q;

endmodule

FILE: src/alte_ctrl.sv
// Command sequencer: decodes each command and steps the datapath walks.
module alte_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  alte_pkg::dp_stat_t stat_i,
  output alte_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_GRAB,
    S_DEL,
    S_INS,
    S_SRCH,
    S_SWAP,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    rsp_valid_d = rsp_valid_q && !rsp_ready_i;
    cmd_o.op    = alte_pkg::DP_NOP;
    cmd_o.st_we = 1'b0;
    cmd_o.st    = alte_pkg::ST_DONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = alte_pkg::DP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (stat_i.cmd)
          alte_pkg::CMD_APPEND: begin
            if (stat_i.can_add) begin
              cmd_o.op    = alte_pkg::DP_APPEND;
              cmd_o.st_we = 1'b1;
            end
          end
          alte_pkg::CMD_INSERT: begin
            if (stat_i.can_add && stat_i.pos_le_cnt) begin
              cmd_o.op = alte_pkg::DP_INS_INIT;
              state_d  = S_INS;
            end
          end
          alte_pkg::CMD_DELETE, alte_pkg::CMD_GET: begin
            if (stat_i.pos_lt_cnt) begin
              cmd_o.op = alte_pkg::DP_RD_POS;
              state_d  = S_GRAB;
            end
          end
          alte_pkg::CMD_SET: begin
            if (stat_i.pos_lt_cnt) begin
              cmd_o.op    = alte_pkg::DP_SET;
              cmd_o.st_we = 1'b1;
            end
          end
          alte_pkg::CMD_SEARCH: begin
            cmd_o.op    = alte_pkg::DP_SRCH_INIT;
            cmd_o.st_we = 1'b1;
            cmd_o.st    = alte_pkg::ST_MISS;
            state_d     = S_SRCH;
          end
          default: begin
          end
        endcase
      end
      S_GRAB: begin
        cmd_o.op    = alte_pkg::DP_GRAB;
        cmd_o.st_we = 1'b1;
        state_d     = (stat_i.cmd == alte_pkg::CMD_DELETE) ? S_DEL : S_FINISH;
      end
      S_DEL: begin
        if (stat_i.scan_done) begin
          cmd_o.op = alte_pkg::DP_DEL_END;
          state_d  = S_FINISH;
        end else begin
          cmd_o.op = alte_pkg::DP_DEL_STEP;
        end
      end
      S_INS: begin
        if (stat_i.ins_done) begin
          cmd_o.op    = alte_pkg::DP_INS_PUT;
          cmd_o.st_we = 1'b1;
          state_d     = S_FINISH;
        end else begin
          cmd_o.op = alte_pkg::DP_INS_STEP;
        end
      end
      S_SRCH: begin
        if (stat_i.hit) begin
          cmd_o.op    = alte_pkg::DP_HIT;
          cmd_o.st_we = 1'b1;
          state_d     = stat_i.swap_need ? S_SWAP : S_FINISH;
        end else if (stat_i.scan_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = alte_pkg::DP_SRCH_STEP;
        end
      end
      S_SWAP: begin
        cmd_o.op = alte_pkg::DP_SWAP_TAIL;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.op    = alte_pkg::DP_EMIT;
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

endmodule

FILE: src/array_list_table_engine_unit.sv
// Top level of the array list table engine: ordered list with self-organizing search.
// Usage: req_i carries one command beat (command, position, operand_value); rsp_o
//   returns exactly one result beat per command (status, read_value,
//   found_position, entry_total). cfg_i writes search_policy (index 0) and
//   capacity_limit (index 1); it is always ready and is meant to be used
//   while no command is in flight.
// Throughput: one command is processed at a time. Insert walks the shifted
//   tail through the list memory one word per cycle, and delete walks the
//   words behind the removed entry forward the same way. Search reads the
//   list from the head until the first hit or the end, with a swap step
//   after a hit away from the head under the transpose or move-to-front policy.
// Reset: the list becomes empty, search_policy returns to plain and
//   capacity_limit to 32. List words are not cleared; only written entries
//   are ever read.
// Stall: a finished result waits in the output register; the next command is
//   still accepted and runs, and its result is held until the beat ahead is taken.
module array_list_table_engine_unit #(
  parameter int unsigned LIST_CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alte_req_if.sink   req_i,
  alte_rsp_if.source rsp_o,
  alte_cfg_if.sink   cfg_i
);

  alte_pkg::dp_cmd_t  dp_cmd;
  alte_pkg::dp_stat_t dp_stat;

  // Configuration writes go straight into their registers; never stall them.
  assign cfg_i.ready = 1'b1;

  alte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  alte_datapath #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .command_i        (req_i.command),
    .position_i       (req_i.position),
    .operand_value_i  (req_i.operand_value),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .status_o         (rsp_o.status),
    .read_value_o     (rsp_o.read_value),
    .found_position_o (rsp_o.found_position),
    .entry_total_o    (rsp_o.entry_total)
  );

endmodule

FILE: src/alte_checker.sv
// Port-level assertions for the array list table engine, bound to the top level.
module alte_checker #(
  parameter int unsigned LIST_CAPACITY = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [alte_pkg::STAT_W-1:0]         rsp_status,
  input logic signed [alte_pkg::DATA_W-1:0]  rsp_read_value,
  input logic [alte_pkg::POS_W-1:0]          rsp_found_position,
  input logic [alte_pkg::CNT_W-1:0]          rsp_entry_total
);

  localparam int unsigned CntMax  = (1 << alte_pkg::CNT_W) - 1;
  localparam int unsigned CapClip = (LIST_CAPACITY > CntMax) ? CntMax : LIST_CAPACITY;

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_read_value) && $stable(rsp_found_position) &&
      $stable(rsp_entry_total))
    else $error("result beat changed while stalled");

  // One command at a time: no new beat is taken right after an accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in flight");

  // A refused or missed command reports no word and no position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status != alte_pkg::ST_DONE) |->
      (rsp_read_value == '0) && (rsp_found_position == '0))
    else $error("failed command returned data");

  // The list never grows past its storage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (int'(rsp_entry_total) <= CapClip))
    else $error("entry total beyond capacity");

endmodule

bind array_list_table_engine_unit alte_checker #(
  .LIST_CAPACITY (LIST_CAPACITY)
) u_alte_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid          (req_i.valid),
  .req_ready          (req_i.ready),
  .rsp_valid          (rsp_o.valid),
  .rsp_ready          (rsp_o.ready),
  .rsp_status         (rsp_o.status),
  .rsp_read_value     (rsp_o.read_value),
  .rsp_found_position (rsp_o.found_position),
  .rsp_entry_total    (rsp_o.entry_total)
);

FILE: test/testbench.sv
// Self-checking testbench for the array list table engine unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import alte_pkg::*;

  localparam int unsigned LIST_CAP        = 32;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = LIST_CAP + 10;
  localparam int unsigned CYCLE_LIMIT     = 300000;

  // Command codes the block leaves undefined; both must be refused.
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  // Register index with no register behind it; a write must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] operand;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [CNT_W-1:0]  entry_total;
  } list_rsp_t;

  // Shadow of the list contents, the entry count and both registers.
  typedef struct packed {
    logic [LIST_CAP-1:0][DATA_W-1:0] words;
    logic [CNT_W-1:0]                count;
    logic [1:0]                      policy;
    logic [CFG_DATA_W-1:0]           cap_limit;
  } list_state_t;

  logic clk_i;
  logic rst_ni;

  alte_req_if req_bus ();
  alte_rsp_if rsp_bus ();
  alte_cfg_if cfg_bus ();

  array_list_table_engine_unit #(
    .LIST_CAPACITY(LIST_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus),
    .cfg_i (cfg_bus)
  );

  list_cmd_t   pending_q[$];   // commands waiting for the driver
  list_rsp_t   expected_q[$];  // predicted result beats, oldest first
  list_state_t model_state;    // advanced on every accepted command beat
  list_state_t gen_state;      // advanced as commands are queued, steers stimulus

  int  error_count  = 0;
  int  result_beats = 0;
  int  send_gap     = 0;
  int  rsp_gap      = 0;
  int  hold_left    = 0;
  int  cycle_count  = 0;
  bit  hold_taken   = 1'b0;
  bit  long_hold_req;
  bit  quiet;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Apply one command to a list state and work out its result beat.
  function automatic void list_apply(inout list_state_t st, input list_cmd_t c,
                                     output list_rsp_t r);
    logic [CNT_W-1:0]  room;
    logic [DATA_W-1:0] held;
    int                i;
    bit                hit;
    r        = '0;
    r.status = ST_RANGE;
    hit      = 1'b0;
    // Clamp the capacity register to the physical list size.
    room = (st.cap_limit < LIST_CAP) ? st.cap_limit : CNT_W'(LIST_CAP);
    case (c.command)
      CMD_APPEND: begin
        if (st.count < room) begin
          st.words[st.count] = c.operand;
          st.count           = st.count + 1'b1;
          r.status           = ST_DONE;
        end
      end
      CMD_INSERT: begin
        // Position equal to the count is a legal insert at the tail.
        if (st.count < room && c.position <= st.count) begin
          for (i = int'(st.count); i > int'(c.position); i--)
            st.words[i] = st.words[i-1];
          st.words[c.position] = c.operand;
          st.count             = st.count + 1'b1;
          r.status             = ST_DONE;
        end
      end
      CMD_DELETE: begin
        if (c.position < st.count) begin
          r.read_value = st.words[c.position];
          for (i = int'(c.position); i + 1 < int'(st.count); i++)
            st.words[i] = st.words[i+1];
          st.count = st.count - 1'b1;
          r.status = ST_DONE;
        end
      end
      CMD_GET: begin
        if (c.position < st.count) begin
          r.read_value = st.words[c.position];
          r.status     = ST_DONE;
        end
      end
      CMD_SET: begin
        if (c.position < st.count) begin
          st.words[c.position] = c.operand;
          r.status             = ST_DONE;
        end
      end
      CMD_SEARCH: begin
        r.status = ST_MISS;
        for (i = 0; i < int'(st.count); i++) begin
          if (!hit && st.words[i] == c.operand) begin
            hit              = 1'b1;
            r.status         = ST_DONE;
            r.found_position = POS_W'(i);
            // A hit at the head never moves; policy 3 falls through as plain.
            if (st.policy == POL_TRANSPOSE && i > 0) begin
              held          = st.words[i];
              st.words[i]   = st.words[i-1];
              st.words[i-1] = held;
            end else if (st.policy == POL_FRONT && i > 0) begin
              held        = st.words[i];
              st.words[i] = st.words[0];
              st.words[0] = held;
            end
          end
        end
      end
      default: ;
    endcase
    r.entry_total = st.count;
  endfunction

  // Queue one command and advance the steering copy of the list.
  function automatic void queue_item(input logic [CMD_W-1:0] cmd,
                                     input logic [POS_W-1:0] pos,
                                     input logic [DATA_W-1:0] val);
    list_cmd_t c;
    list_rsp_t scratch;
    c.command  = cmd;
    c.position = pos;
    c.operand  = val;
    list_apply(gen_state, c, scratch);
    pending_q.push_back(c);
  endfunction

  // Queue n random commands. Weights pick the command mix; positions mostly
  // land inside the list and search keys often hit a word that is present.
  function automatic void fill_random(input int n, input int w_app, input int w_ins,
                                      input int w_del, input int w_get,
                                      input int w_set, input int w_find);
    int                k;
    int                r;
    int                bound;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, w_app + w_ins + w_del + w_get + w_set + w_find - 1);
      if ($urandom_range(0, 49) == 0) begin
        cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
      end else if (r < w_app) begin
        cmd = CMD_APPEND;
      end else if (r < w_app + w_ins) begin
        cmd = CMD_INSERT;
      end else if (r < w_app + w_ins + w_del) begin
        cmd = CMD_DELETE;
      end else if (r < w_app + w_ins + w_del + w_get) begin
        cmd = CMD_GET;
      end else if (r < w_app + w_ins + w_del + w_get + w_set) begin
        cmd = CMD_SET;
      end else begin
        cmd = CMD_SEARCH;
      end

      bound = (cmd == CMD_INSERT) ? int'(gen_state.count) : int'(gen_state.count) - 1;
      if (bound > 31) bound = 31;
      if (bound >= 0 && $urandom_range(0, 19) < 17) begin
        pos = POS_W'($urandom_range(0, bound));
      end else begin
        pos = POS_W'($urandom_range(0, 31));
      end

      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if (gen_state.count != 0) begin
            val = gen_state.words[$urandom_range(0, gen_state.count - 1)];
          end else begin
            val = $urandom;
          end
        end
        4, 5, 6: begin
          // Narrow spread around zero so duplicate words are common.
          val = DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
        end
        7: begin
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = '1;
            default: val = '0;
          endcase
        end
        default: val = $urandom;
      endcase
      queue_item(cmd, pos, val);
    end
  endfunction

  // Hold until every queued command is accepted and every result has come back.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || req_bus.valid || expected_q.size() != 0);
  endtask

  // Write one register over the configuration channel; call only while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      CFG_SEARCH_POLICY:  model_state.policy    = val[1:0];
      CFG_CAPACITY_LIMIT: model_state.cap_limit = val;
      default: ;
    endcase
    gen_state = model_state;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("[%0t] result beat %0d: %s got %h, predicted %h",
             $realtime, result_beats, what, got_v, want_v);
    error_count++;
  endtask

  // Command driver: offer the next pending command, with random idle bursts
  // between beats unless the run is in its quiet tail.
  always @(posedge clk_i) begin
    list_cmd_t nxt;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 4);
        req_bus.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        req_bus.valid         <= 1'b1;
        req_bus.command       <= nxt.command;
        req_bus.position      <= nxt.position;
        req_bus.operand_value <= nxt.operand;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result ready: one long hold-off when requested, then random stall
  // bursts, none in the quiet tail.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_OFF_CYCLES - 1;
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_gap = $urandom_range(0, 4);
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  // Monitor: check each result beat against the oldest prediction, then
  // predict the result of any command beat accepted at this edge.
  always @(posedge clk_i) begin
    list_rsp_t want;
    list_rsp_t fresh;
    list_cmd_t seen;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat, status", 32'(rsp_bus.status), '0);
        end else begin
          want = expected_q.pop_front();
          if (rsp_bus.status !== want.status)
            report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
          if (rsp_bus.read_value !== want.read_value)
            report_mismatch("read_value", rsp_bus.read_value, want.read_value);
          if (rsp_bus.found_position !== want.found_position)
            report_mismatch("found_position", 32'(rsp_bus.found_position),
                            32'(want.found_position));
          if (rsp_bus.entry_total !== want.entry_total)
            report_mismatch("entry_total", 32'(rsp_bus.entry_total),
                            32'(want.entry_total));
        end
        result_beats++;
      end
      if (req_bus.valid && req_bus.ready) begin
        seen.command  = req_bus.command;
        seen.position = req_bus.position;
        seen.operand  = req_bus.operand_value;
        list_apply(model_state, seen, fresh);
        expected_q.push_back(fresh);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known level before the first edge.
    rst_ni                = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.command       = '0;
    req_bus.position      = '0;
    req_bus.operand_value = '0;
    rsp_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = '0;
    cfg_bus.data          = '0;
    long_hold_req         = 1'b0;
    quiet                 = 1'b0;
    model_state           = '0;
    model_state.cap_limit = CAP_RESET;
    gen_state             = model_state;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats under the reset settings: empty-list refusals, inserts
    // at the head and at the tail, boundary positions, extreme words,
    // undefined commands and a first-match search over a duplicate.
    queue_item(CMD_SEARCH, 5'd0,  32'h0000_0000);
    queue_item(CMD_GET,    5'd0,  32'h0000_0000);
    queue_item(CMD_DELETE, 5'd0,  32'h0000_0000);
    queue_item(CMD_SET,    5'd0,  32'h1111_1111);
    queue_item(CMD_INSERT, 5'd1,  32'h2222_2222);
    queue_item(CMD_INSERT, 5'd0,  32'h8000_0000);
    queue_item(CMD_APPEND, 5'd0,  32'h7FFF_FFFF);
    queue_item(CMD_APPEND, 5'd31, 32'hFFFF_FFFF);
    queue_item(CMD_APPEND, 5'd0,  32'h0000_0000);
    queue_item(CMD_INSERT, 5'd4,  32'h5555_5555);
    queue_item(CMD_INSERT, 5'd1,  32'hAAAA_AAAA);
    queue_item(CMD_GET,    5'd6,  32'h0000_0000);
    queue_item(CMD_GET,    5'd31, 32'h0000_0000);
    queue_item(CMD_GET,    5'd1,  32'h0000_0000);
    queue_item(CMD_SET,    5'd0,  32'h0000_0001);
    queue_item(CMD_SEARCH, 5'd0,  32'hFFFF_FFFF);
    queue_item(CMD_SEARCH, 5'd0,  32'h1234_5678);
    queue_item(CMD_DELETE, 5'd5,  32'h0000_0000);
    queue_item(CMD_DELETE, 5'd0,  32'h0000_0000);
    queue_item(CMD_DELETE, 5'd4,  32'h0000_0000);
    queue_item(CMD_SPARE_6, 5'd0, 32'h0000_0000);
    queue_item(CMD_SPARE_7, 5'd31, 32'hFFFF_FFFF);
    queue_item(CMD_APPEND, 5'd0,  32'h7FFF_FFFF);
    queue_item(CMD_SEARCH, 5'd0,  32'h7FFF_FFFF);
    wait_idle();

    // Oversized capacity clamps to the list size; fill the list to full.
    write_reg(CFG_CAPACITY_LIMIT, 6'd63);
    @(negedge clk_i);
    fill_random(80, 6, 3, 1, 1, 1, 2);
    wait_idle();

    // Transpose policy with a search-heavy mix.
    write_reg(CFG_SEARCH_POLICY, 6'd1);
    write_reg(CFG_CAPACITY_LIMIT, 6'd32);
    @(negedge clk_i);
    fill_random(80, 2, 2, 2, 1, 1, 5);
    wait_idle();

    // Move-to-front policy; stall results for a long stretch while commands
    // keep coming, so the block backs up and stalls its command input.
    write_reg(CFG_SEARCH_POLICY, 6'd2);
    @(negedge clk_i);
    long_hold_req = 1'b1;
    fill_random(80, 3, 2, 2, 1, 1, 4);
    // Leave the list well above the next capacity setting.
    while (gen_state.count < 12) queue_item(CMD_APPEND, '0, $urandom);
    wait_idle();

    // Undefined policy code with every data bit set; capacity below the count.
    write_reg(CFG_SEARCH_POLICY, 6'h3F);
    write_reg(CFG_CAPACITY_LIMIT, 6'd5);
    @(negedge clk_i);
    fill_random(60, 2, 2, 4, 2, 2, 3);
    wait_idle();

    // Write to the unused index, then plain search and a capacity of one.
    write_reg(CFG_UNUSED, 6'h2A);
    write_reg(CFG_SEARCH_POLICY, 6'd4);
    write_reg(CFG_CAPACITY_LIMIT, 6'd1);
    @(negedge clk_i);
    fill_random(50, 2, 2, 3, 2, 2, 2);
    wait_idle();

    // Zero capacity: nothing can be added.
    write_reg(CFG_CAPACITY_LIMIT, 6'd0);
    @(negedge clk_i);
    fill_random(30, 3, 3, 3, 2, 2, 2);
    wait_idle();

    // Quiet tail: full rate on both sides.
    write_reg(CFG_SEARCH_POLICY, 6'd2);
    write_reg(CFG_CAPACITY_LIMIT, 6'd32);
    @(negedge clk_i);
    quiet = 1'b1;
    fill_random(120, 3, 2, 2, 1, 1, 4);
    wait_idle();

    // Let any stray beat show up before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
